@@ rtl/core/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/spq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compares against the incoming key and
// shifts with its neighbors on push and pop
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_WIDTH = 32
)
(
    input  wire                         clk,
    input  cell_ctrl_t                  ctrl,
    input  wire                         occupied,
    input  wire signed [KEY_WIDTH-1:0]  new_key,
    input  wire                         prev_stay,
    input  wire signed [KEY_WIDTH-1:0]  prev_key,
    input  wire signed [KEY_WIDTH-1:0]  next_key,
    output logic signed [KEY_WIDTH-1:0] key_out,
    output logic                        stay
);

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;

    // stored key is greater or equal, so it keeps its place
    assign stay    = occupied && !(key_reg < new_key);
    assign key_out = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.push && !stay)
        begin
            key_next = prev_stay ? new_key : prev_key;
        end
        else if (ctrl.pop)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue of signed keys held in descending order in a chain
// of compare-and-shift cells
// ----------------------------------------------------------------------------
// result: registered in the cycle after the input transfer
// throughput: one push or pop per cycle while the input is not stalled; the cells compare in parallel
// input is stalled only while a result waits and the output is stalled
// reset clears the entry count and the output valid register; key cells are not reset
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                op,
    input  wire signed [KEY_WIDTH-1:0]         key,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [KEY_WIDTH-1:0]        popped_key,
    output logic                               popped_valid,
    output logic [1:0]                         status,
    output logic [$clog2(CAPACITY+1)-1:0]      occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        out_valid_reg;
    logic signed [KEY_WIDTH-1:0] popped_key_reg;
    logic signed [KEY_WIDTH-1:0] popped_key_next;
    logic                        popped_valid_reg;
    logic                        popped_valid_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;

    logic                        accept;
    logic                        full;
    logic                        empty;
    cell_ctrl_t                  ctrl;

    logic signed [KEY_WIDTH-1:0] cell_key  [CAPACITY];
    logic                        cell_stay [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign ctrl.push = accept && (op == OP_PUSH) && !full;
    assign ctrl.pop  = accept && (op == OP_POP) && !empty;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                        prev_stay;
            logic signed [KEY_WIDTH-1:0] prev_key;
            logic signed [KEY_WIDTH-1:0] next_key;

            if (i == 0)
            begin : g_head
                assign prev_stay = 1'b1;
                assign prev_key  = key;
            end
            else
            begin : g_body
                assign prev_stay = cell_stay[i-1];
                assign prev_key  = cell_key[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign next_key = cell_key[i];
            end
            else
            begin : g_link
                assign next_key = cell_key[i+1];
            end

            spq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (CW'(i) < count_reg),
                .new_key   (key),
                .prev_stay (prev_stay),
                .prev_key  (prev_key),
                .next_key  (next_key),
                .key_out   (cell_key[i]),
                .stay      (cell_stay[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next        = count_reg;
        popped_key_next   = '0;
        popped_valid_next = 1'b0;
        status_next       = STATUS_OK;
        if (op == OP_PUSH)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                count_next        = count_reg - CW'(1);
                popped_key_next   = cell_key[0];
                popped_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_key_reg   <= popped_key_next;
            popped_valid_reg <= popped_valid_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_key   = popped_key_reg;
    assign popped_valid = popped_valid_reg;
    assign status       = status_reg;
    assign occupancy    = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(2) |-> cell_key[0] >= cell_key[1])
        else $error("head cells out of order");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not decrement count");

    a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && popped_valid_reg |-> status_reg == STATUS_OK)
        else $error("popped key with error status");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(count_reg))
        else $error("stalled result lost");

endmodule
`default_nettype wire

@@ bench/tb_sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// self-checking bench for the sorted priority queue: a driver feeds push and
// pop operations from a backlog, a monitor predicts each outcome from its own
// ranked key list and compares every output transfer field by field
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int CAP   = 16;
    localparam int KW    = 32;
    localparam int OCC_W = $clog2(CAP + 1);

    typedef struct {
        logic                 drain;
        logic                 op;
        logic signed [KW-1:0] key;
    } queue_op_t;

    typedef struct {
        logic signed [KW-1:0] popped_key;
        logic                 popped_valid;
        logic [1:0]           status;
        logic [OCC_W-1:0]     occupancy;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = OP_PUSH;
    logic signed [KW-1:0] key = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [KW-1:0] popped_key;
    logic                 popped_valid;
    logic [1:0]           status;
    logic [OCC_W-1:0]     occupancy;

    queue_op_t            op_backlog[$];
    outcome_t             due_outcomes[$];
    logic signed [KW-1:0] ranked_keys[CAP];
    int                   ranked_count = 0;
    int                   total_items = 0;
    int                   accepted_count = 0;
    int                   error_count = 0;
    logic                 long_hold = 1'b0;
    int                   send_idle_left = 0;
    int                   recv_stall_left = 0;

    sorted_priority_queue #(
        .CAPACITY  (CAP),
        .KEY_WIDTH (KW)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .key          (key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_key   (popped_key),
        .popped_valid (popped_valid),
        .status       (status),
        .occupancy    (occupancy)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ordered insert behind equal keys, pop from the head
    function automatic outcome_t rank_and_serve(input logic op_in,
                                                input logic signed [KW-1:0] key_in);
        outcome_t res;
        int       pos;
        res.popped_key   = '0;
        res.popped_valid = 1'b0;
        res.status       = STATUS_OK;
        if (op_in == OP_PUSH)
        begin
            if (ranked_count >= CAP)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < ranked_count && ranked_keys[pos] >= key_in)
                    pos++;
                for (int i = ranked_count; i > pos; i--)
                    ranked_keys[i] = ranked_keys[i-1];
                ranked_keys[pos] = key_in;
                ranked_count++;
            end
        end
        else if (ranked_count == 0)
        begin
            res.status = STATUS_EMPTY;
        end
        else
        begin
            res.popped_key   = ranked_keys[0];
            res.popped_valid = 1'b1;
            for (int i = 1; i < ranked_count; i++)
                ranked_keys[i-1] = ranked_keys[i];
            ranked_count--;
        end
        res.occupancy = OCC_W'(ranked_count);
        return res;
    endfunction

    function automatic logic signed [KW-1:0] pick_key();
        logic signed [KW-1:0] k;
        case ($urandom_range(0, 9))
            7:       k = 32'sh7FFF_FFFF;
            8:       k = 32'sh8000_0000;
            9:       k = ($urandom_range(0, 1) == 0) ? 32'sh0 : -32'sh1;
            4, 5, 6: k = KW'($signed($urandom_range(0, 8)) - 4);
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic add_op(input logic op_in, input logic signed [KW-1:0] key_in);
        queue_op_t q;
        q.drain = 1'b0;
        q.op    = op_in;
        q.key   = key_in;
        op_backlog.push_back(q);
        total_items++;
    endtask

    task automatic add_drain();
        queue_op_t q;
        q.drain = 1'b1;
        q.op    = OP_PUSH;
        q.key   = '0;
        op_backlog.push_back(q);
    endtask

    task automatic report_field(input string name, input longint exp_v,
                                input longint act_v);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        error_count++;
    endtask

    // driver
    always @(posedge clk)
    begin
        logic      next_valid;
        logic      just_sent;
        queue_op_t q;
        if (rst_n && !(in_valid && in_stall))
        begin
            just_sent  = in_valid && !in_stall;
            next_valid = 1'b0;
            if (send_idle_left > 0)
            begin
                send_idle_left--;
            end
            else if (op_backlog.size() != 0)
            begin
                if (op_backlog[0].drain)
                begin
                    if (!just_sent && due_outcomes.size() == 0)
                        void'(op_backlog.pop_front());
                end
                else if (op_backlog.size() > 150 && $urandom_range(0, 7) == 0)
                begin
                    send_idle_left = $urandom_range(0, 4);
                end
                else
                begin
                    q = op_backlog.pop_front();
                    op  <= q.op;
                    key <= q.key;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        outcome_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, actual key %0d status %0d",
                             $time, popped_key, status);
                    error_count++;
                end
                else
                begin
                    exp_r = due_outcomes.pop_front();
                    if (popped_key !== exp_r.popped_key)
                        report_field("popped_key", exp_r.popped_key, popped_key);
                    if (popped_valid !== exp_r.popped_valid)
                        report_field("popped_valid", exp_r.popped_valid, popped_valid);
                    if (status !== exp_r.status)
                        report_field("status", exp_r.status, status);
                    if (occupancy !== exp_r.occupancy)
                        report_field("occupancy", exp_r.occupancy, occupancy);
                end
            end
            if (in_valid && !in_stall)
            begin
                due_outcomes.push_back(rank_and_serve(op, key));
                accepted_count++;
            end
            if (long_hold)
            begin
                out_stall <= 1'b1;
            end
            else if (accepted_count > total_items - 150)
            begin
                out_stall <= 1'b0;
            end
            else if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                recv_stall_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // receiver holds off long enough for the queue to back up
    initial
    begin
        wait (accepted_count >= 400);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (80) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        int   seg_len;
        int   push_pct;
        int   made;
        logic drained_mid;
        add_op(OP_POP, pick_key());
        add_op(OP_PUSH, 32'sh0);
        add_op(OP_PUSH, 32'sh7FFF_FFFF);
        add_op(OP_PUSH, 32'sh8000_0000);
        add_op(OP_PUSH, -32'sh1);
        add_op(OP_PUSH, 32'sh1);
        add_op(OP_PUSH, 32'sh5);
        add_op(OP_PUSH, 32'sh5);
        add_op(OP_PUSH, 32'sh5);
        add_op(OP_PUSH, -32'sh5);
        add_op(OP_PUSH, 32'shAAAA_AAAA);
        add_op(OP_PUSH, 32'sh5555_5555);
        add_op(OP_PUSH, 32'sh0);
        add_op(OP_PUSH, 32'sh7FFF_FFFF);
        add_op(OP_PUSH, 32'sh8000_0000);
        add_op(OP_PUSH, 32'sh100);
        add_op(OP_PUSH, -32'sh100);
        add_op(OP_PUSH, 32'sh7FFF_FFFF);
        add_op(OP_PUSH, 32'sh8000_0000);
        repeat (5) add_op(OP_POP, pick_key());
        add_drain();

        // segments of push-heavy, balanced and pop-heavy traffic
        made = 0;
        drained_mid = 1'b0;
        while (made < 1430)
        begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            repeat (seg_len)
            begin
                add_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick_key());
                made++;
            end
            if (!drained_mid && made >= 800)
            begin
                add_drain();
                drained_mid = 1'b1;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_count == total_items);
        wait (due_outcomes.size() == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
